FILE: rtl/kdb_pkg.sv
// Shared types, constants and register indexes for the key debouncer with queue.
// No dependencies; the files that use it refer to it by scoped names.
package kdb_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int KEY_W       = 8;
   localparam int COUNT_OUT_W = 4;
   localparam int CSR_IDX_W   = 2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_CODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_MASK     = 2'd2;

   localparam logic [KEY_W-1:0] DEBOUNCE_COUNT_RST = 8'd3;
   localparam logic [KEY_W-1:0] NONE_CODE_RST      = 8'd0;
   localparam logic [KEY_W-1:0] EVENT_MASK_RST     = 8'd64;

   typedef struct packed {
      logic [KEY_W-1:0] debounce_count;
      logic [KEY_W-1:0] none_code;
      logic [KEY_W-1:0] event_mask;
   } cfg_type;

   typedef struct packed {
      logic             req;
      logic [KEY_W-1:0] key;
   } push_type;

   typedef struct packed {
      logic                   hit;
      logic                   queued;
      logic [QUEUE_CNT_W-1:0] fill;
   } queue_status_type;

endpackage

FILE: rtl/kdb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kdb_debounce.sv
// Event key filter and four-phase press/release debouncer.
// Depends on kdb_pkg; produces push requests for kdb_queue.
module kdb_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      opcode,
   input  logic [kdb_pkg::KEY_W-1:0] raw_key,
   input  kdb_pkg::cfg_type          cfg,
   output kdb_pkg::push_type         push
);

   localparam logic [1:0] PH_WAIT_PRESS   = 2'd0;
   localparam logic [1:0] PH_PRESS        = 2'd1;
   localparam logic [1:0] PH_WAIT_RELEASE = 2'd2;
   localparam logic [1:0] PH_RELEASE      = 2'd3;

   logic [1:0]                phase_ff, phase_in;
   logic [kdb_pkg::KEY_W-1:0] timer_ff, timer_in;
   logic [kdb_pkg::KEY_W-1:0] held_ff, held_in;
   logic                      is_event;
   logic                      fsm_push;
   logic                      key_none;
   logic                      key_same;
   logic                      timer_zero;

   assign is_event   = (raw_key & cfg.event_mask) != '0;
   assign key_none   = raw_key == cfg.none_code;
   assign key_same   = held_ff == raw_key;
   assign timer_zero = timer_ff == '0;

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      held_in  = held_ff;
      fsm_push = 1'b0;
      unique case (phase_ff)
         PH_WAIT_PRESS: begin
            if (!key_none) begin
               timer_in = cfg.debounce_count;
               held_in  = raw_key;
               phase_in = PH_PRESS;
            end
         end
         PH_PRESS: begin
            if (!key_same) begin
               phase_in = PH_WAIT_PRESS;
            end else if (timer_zero) begin
               phase_in = PH_WAIT_RELEASE;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         PH_WAIT_RELEASE: begin
            if (key_none) begin
               timer_in = cfg.debounce_count;
               phase_in = PH_RELEASE;
            end else if (!key_same) begin
               phase_in = PH_WAIT_PRESS;
            end
         end
         PH_RELEASE: begin
            if (key_same) begin
               phase_in = PH_WAIT_RELEASE;
            end else if (timer_zero) begin
               phase_in = PH_WAIT_PRESS;
               fsm_push = 1'b1;
            end else if (!key_none) begin
               phase_in = PH_WAIT_PRESS;
            end else begin
               timer_in = timer_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_WAIT_PRESS;
         end
      endcase
   end

   always_comb begin
      push.req = 1'b0;
      push.key = held_ff;
      if (opcode == kdb_pkg::OP_SAMPLE) begin
         if (is_event) begin
            push.req = 1'b1;
            push.key = raw_key & ~cfg.event_mask;
         end else begin
            push.req = fsm_push;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_PRESS;
         timer_ff <= '0;
         held_ff  <= '0;
      end else if (en && opcode == kdb_pkg::OP_SAMPLE && !is_event) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         held_ff  <= held_in;
      end
   end

endmodule

FILE: rtl/kdb_queue.sv
// Circular key queue: head and fill pointers with overwrite-oldest on full.
// Depends on kdb_pkg and kdb_ram; read data is registered in the RAM and arrives in the cycle after the pop.
module kdb_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      pop,
   input  kdb_pkg::push_type         push,
   input  logic [kdb_pkg::KEY_W-1:0] none_code,
   output kdb_pkg::queue_status_type status,
   output logic [kdb_pkg::KEY_W-1:0] rd_data
);

   localparam int IDX_W = kdb_pkg::QUEUE_IDX_W;
   localparam int CNT_W = kdb_pkg::QUEUE_CNT_W;
   localparam int SUM_W = CNT_W + 1;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] head_next;
   logic [SUM_W-1:0] tail_sum;
   logic [IDX_W-1:0] tail;
   logic             pop_hit;
   logic             push_ok;
   logic             wr_en;
   logic             rd_en;

   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(fill_ff);
   assign tail      = (tail_sum >= SUM_W'(kdb_pkg::QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - SUM_W'(kdb_pkg::QUEUE_DEPTH))
                      : IDX_W'(tail_sum);
   assign head_next = (head_ff == IDX_W'(kdb_pkg::QUEUE_DEPTH - 1))
                      ? '0 : head_ff + 1'b1;
   assign pop_hit   = en && pop && (fill_ff != '0);
   assign push_ok   = en && !pop && push.req && (push.key != none_code);

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      if (pop_hit) begin
         head_in = head_next;
         fill_in = fill_ff - 1'b1;
         rd_en   = 1'b1;
      end else if (push_ok) begin
         wr_en = 1'b1;
         if (fill_ff == CNT_W'(kdb_pkg::QUEUE_DEPTH)) begin
            head_in = head_next;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   assign status.hit    = pop_hit;
   assign status.queued = push_ok;
   assign status.fill   = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   kdb_ram #(
      .WIDTH (kdb_pkg::KEY_W),
      .DEPTH (kdb_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (push.key),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

endmodule

FILE: rtl/key_debouncer_with_fifo.sv
// Key debouncer with key queue: one item accepted per cycle while req_stall is low, result registered and valid
// in the next cycle; the rate is set by the queue pointer update loop.
// The result register holds while rsp_stall is high; req_stall follows it then.
// Synchronous active-high reset clears phase, timer, held key, pointers and the
// registers (debounce_count 3, none_code 0, event_mask 64); queue contents are not cleared.
// Depends on kdb_pkg, kdb_debounce, kdb_queue and kdb_ram.
module key_debouncer_with_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [kdb_pkg::KEY_W-1:0]       req_raw_key,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kdb_pkg::KEY_W-1:0]       rsp_popped_key,
   output logic [kdb_pkg::COUNT_OUT_W-1:0] rsp_queue_count,
   output logic                            rsp_key_queued,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kdb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kdb_pkg::KEY_W-1:0]       csr_data
);

   localparam int CNT_W = kdb_pkg::QUEUE_CNT_W;
   localparam int OUT_W = kdb_pkg::COUNT_OUT_W;

   kdb_pkg::cfg_type          cfg_ff;
   kdb_pkg::push_type         push;
   kdb_pkg::queue_status_type status;
   logic [kdb_pkg::KEY_W-1:0] rd_data;
   logic                      accept;
   logic                      is_pop;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      hit_ff;
   logic                      queued_ff;
   logic [kdb_pkg::KEY_W-1:0] none_ff;
   logic [OUT_W-1:0]          count_ff;
   logic [CNT_W+OUT_W-1:0]    fill_wide;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count <= kdb_pkg::DEBOUNCE_COUNT_RST;
         cfg_ff.none_code      <= kdb_pkg::NONE_CODE_RST;
         cfg_ff.event_mask     <= kdb_pkg::EVENT_MASK_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            kdb_pkg::CSR_DEBOUNCE_COUNT: cfg_ff.debounce_count <= csr_data;
            kdb_pkg::CSR_NONE_CODE:      cfg_ff.none_code      <= csr_data;
            kdb_pkg::CSR_EVENT_MASK:     cfg_ff.event_mask     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_pop    = req_opcode == kdb_pkg::OP_POP;

   kdb_debounce u_debounce (
      .clock   (clock),
      .reset   (reset),
      .en      (accept),
      .opcode  (req_opcode),
      .raw_key (req_raw_key),
      .cfg     (cfg_ff),
      .push    (push)
   );

   kdb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .en        (accept),
      .pop       (is_pop),
      .push      (push),
      .none_code (cfg_ff.none_code),
      .status    (status),
      .rd_data   (rd_data)
   );

   assign fill_wide    = {{OUT_W{1'b0}}, status.fill};
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff    <= status.hit;
         queued_ff <= status.queued;
         none_ff   <= cfg_ff.none_code;
         count_ff  <= fill_wide[OUT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_popped_key  = hit_ff ? rd_data : none_ff;
   assign rsp_queue_count = count_ff;
   assign rsp_key_queued  = queued_ff;

endmodule

FILE: rtl/kdb_checker.sv
// Port-level checks for key_debouncer_with_fifo, attached by the bind below.
// Depends on kdb_pkg.
module kdb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_opcode,
   input logic [kdb_pkg::KEY_W-1:0]       req_raw_key,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [kdb_pkg::KEY_W-1:0]       rsp_popped_key,
   input logic [kdb_pkg::COUNT_OUT_W-1:0] rsp_queue_count,
   input logic                            rsp_key_queued,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [kdb_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [kdb_pkg::KEY_W-1:0]       csr_data
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_item_yields_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   a_stall_only_on_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_popped_key)
         && $stable(rsp_queue_count) && $stable(rsp_key_queued))
      else $error("stalled result changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (kdb_pkg::QUEUE_DEPTH > 15)
         || (int'(rsp_queue_count) <= kdb_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

bind key_debouncer_with_fifo kdb_checker u_kdb_checker (.*);
